>>> design/lrupr_pkg.sv
// Shared control types for the LRU page replacement unit.
`timescale 1ns / 1ps

package lrupr_pkg;

	// Flags of the search packet that travels down the row of frame cells.
	typedef struct packed {
		logic valid;        // a packet is present in this stage
		logic hit;          // some earlier cell holds the requested page
		logic empty_found;  // some earlier cell is an empty frame
		logic lru_set;      // the oldest-frame candidate has been taken
	} lrupr_flags_t;

	// Update broadcast to every cell when a request completes.
	typedef struct packed {
		logic commit;  // apply aging and the placement this cycle
		logic write;   // the request faulted: the chosen frame takes the page
	} lrupr_update_t;

	localparam int unsigned COUNT_BITS = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam int unsigned PAGE_PORT_BITS = 8;
	localparam int unsigned SLOT_PORT_BITS = 2;

endpackage

>>> design/lrupr_cell.sv
// One frame cell: holds a frame and forwards the search packet to its neighbor.
`timescale 1ns / 1ps

module lrupr_cell #(
	parameter int PAGE_BITS = 8,
	parameter int AGE_BITS  = 16,
	parameter int SLOT_W    = 2,
	parameter int IDX       = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lrupr_pkg::lrupr_flags_t   flags_in,
	input  logic [PAGE_BITS-1:0]      page_in,
	input  logic [SLOT_W-1:0]         hit_idx_in,
	input  logic [SLOT_W-1:0]         empty_idx_in,
	input  logic [AGE_BITS-1:0]       best_age_in,
	input  logic [SLOT_W-1:0]         best_idx_in,
	input  logic [PAGE_BITS-1:0]      best_page_in,
	input  logic                      hold,
	output lrupr_pkg::lrupr_flags_t   flags_out,
	output logic [PAGE_BITS-1:0]      page_out,
	output logic [SLOT_W-1:0]         hit_idx_out,
	output logic [SLOT_W-1:0]         empty_idx_out,
	output logic [AGE_BITS-1:0]       best_age_out,
	output logic [SLOT_W-1:0]         best_idx_out,
	output logic [PAGE_BITS-1:0]      best_page_out,
	input  lrupr_pkg::lrupr_update_t  upd,
	input  logic [SLOT_W-1:0]         upd_slot,
	input  logic [PAGE_BITS-1:0]      upd_page
);
	import lrupr_pkg::*;

	localparam logic [SLOT_W-1:0]   MY_IDX  = SLOT_W'(IDX);
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	logic                 valid_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [AGE_BITS-1:0]  age_q;

	lrupr_flags_t         flags_q;
	logic [PAGE_BITS-1:0] pkt_page_q;
	logic [SLOT_W-1:0]    hit_idx_q;
	logic [SLOT_W-1:0]    empty_idx_q;
	logic [AGE_BITS-1:0]  best_age_q;
	logic [SLOT_W-1:0]    best_idx_q;
	logic [PAGE_BITS-1:0] best_page_q;

	lrupr_flags_t         flags_nx;
	logic [SLOT_W-1:0]    hit_idx_nx;
	logic [SLOT_W-1:0]    empty_idx_nx;
	logic [AGE_BITS-1:0]  best_age_nx;
	logic [SLOT_W-1:0]    best_idx_nx;
	logic [PAGE_BITS-1:0] best_page_nx;

	// Fold this frame into the packet: first hit, first empty frame, oldest frame.
	always_comb begin
		flags_nx     = flags_in;
		hit_idx_nx   = hit_idx_in;
		empty_idx_nx = empty_idx_in;
		best_age_nx  = best_age_in;
		best_idx_nx  = best_idx_in;
		best_page_nx = best_page_in;
		if (!flags_in.hit && valid_q && page_q == page_in) begin
			flags_nx.hit = 1'b1;
			hit_idx_nx   = MY_IDX;
		end
		if (!flags_in.empty_found && !valid_q) begin
			flags_nx.empty_found = 1'b1;
			empty_idx_nx         = MY_IDX;
		end
		if (!flags_in.lru_set || age_q > best_age_in) begin
			flags_nx.lru_set = 1'b1;
			best_age_nx      = age_q;
			best_idx_nx      = MY_IDX;
			best_page_nx     = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (flags_in.valid) begin
			flags_q <= flags_nx;
		end else begin
			flags_q.valid <= flags_q.valid & hold;
		end
	end

	always_ff @(posedge clk) begin
		if (flags_in.valid) begin
			pkt_page_q  <= page_in;
			hit_idx_q   <= hit_idx_nx;
			empty_idx_q <= empty_idx_nx;
			best_age_q  <= best_age_nx;
			best_idx_q  <= best_idx_nx;
			best_page_q <= best_page_nx;
		end
	end

	// Frame state: placement and aging when a request completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (upd.commit) begin
			if (upd_slot == MY_IDX) begin
				age_q <= '0;
				if (upd.write) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && age_q != AGE_MAX) begin
				age_q <= age_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.commit && upd.write && upd_slot == MY_IDX) begin
			page_q <= upd_page;
		end
	end

	assign flags_out     = flags_q;
	assign page_out      = pkt_page_q;
	assign hit_idx_out   = hit_idx_q;
	assign empty_idx_out = empty_idx_q;
	assign best_age_out  = best_age_q;
	assign best_idx_out  = best_idx_q;
	assign best_page_out = best_page_q;

endmodule

>>> design/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit: frame cell row, decision and result register.
`timescale 1ns / 1ps

// Each request carries one page reference. The unit keeps FRAMES page frames in a
// row of identical cells. An accepted request enters the first cell as a search
// packet and moves one cell per clock; every cell checks whether it holds the page,
// whether it is empty, and whether it is older than the oldest frame seen so far.
// When the packet leaves the last cell the unit decides combinationally: a hit keeps
// its frame, a fault takes the lowest-numbered empty frame, or else evicts the least
// recently used frame (greatest age, ties to the lowest index). In that same cycle
// all valid frames age by one (saturating at the top of AGE_BITS) and the used frame
// returns to age zero, and the result is loaded into the output register. The unit
// takes a new request only once the previous one has left the cell row; in_stall
// is high while a request is in the row. A finished result waits in the output
// register, so the next request may enter while the previous result is still stalled;
// it is held at the end of the row until the output register is free. frame_slot
// carries the low two bits of the frame index, and fault_total counts faults since
// reset, stopping at 65535. Only the low PAGE_BITS bits of page_number are used.
module lru_page_replacement_unit #(
	parameter int FRAMES    = 4,
	parameter int PAGE_BITS = 8,
	parameter int AGE_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [lrupr_pkg::PAGE_PORT_BITS-1:0]  page_number,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  fault,
	output logic [lrupr_pkg::SLOT_PORT_BITS-1:0]  frame_slot,
	output logic                                  victim_valid,
	output logic [lrupr_pkg::PAGE_PORT_BITS-1:0]  victim_page,
	output logic [lrupr_pkg::COUNT_BITS-1:0]      fault_total
);
	import lrupr_pkg::*;

	localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	// Packet stages: index 0 is the request entering, index k the output of cell k-1.
	lrupr_flags_t         flags_c     [FRAMES+1];
	logic [PAGE_BITS-1:0] page_c      [FRAMES+1];
	logic [SLOT_W-1:0]    hit_idx_c   [FRAMES+1];
	logic [SLOT_W-1:0]    empty_idx_c [FRAMES+1];
	logic [AGE_BITS-1:0]  best_age_c  [FRAMES+1];
	logic [SLOT_W-1:0]    best_idx_c  [FRAMES+1];
	logic [PAGE_BITS-1:0] best_page_c [FRAMES+1];

	logic                 busy_q;
	logic                 accept;
	logic                 commit;
	lrupr_update_t        upd;
	logic [SLOT_W-1:0]    dec_slot;
	logic                 dec_fault;
	logic                 dec_victim;

	logic [PAGE_PORT_BITS+PAGE_BITS-1:0] page_ext;
	logic [SLOT_W+SLOT_PORT_BITS-1:0]    slot_ext;
	logic [PAGE_BITS+PAGE_PORT_BITS-1:0] victim_ext;

	logic                      out_valid_q;
	logic                      fault_q;
	logic [SLOT_PORT_BITS-1:0] slot_q;
	logic                      victim_valid_q;
	logic [PAGE_PORT_BITS-1:0] victim_page_q;
	logic [COUNT_BITS-1:0]     fault_count_q;

	// Only one request is in the row at a time.
	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;

	assign page_ext = {{PAGE_BITS{1'b0}}, page_number};

	always_comb begin
		flags_c[0]       = '0;
		flags_c[0].valid = accept;
		page_c[0]        = page_ext[PAGE_BITS-1:0];
		hit_idx_c[0]     = '0;
		empty_idx_c[0]   = '0;
		best_age_c[0]    = '0;
		best_idx_c[0]    = '0;
		best_page_c[0]   = '0;
	end

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell #(
			.PAGE_BITS (PAGE_BITS),
			.AGE_BITS  (AGE_BITS),
			.SLOT_W    (SLOT_W),
			.IDX       (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.flags_in      (flags_c[i]),
			.page_in       (page_c[i]),
			.hit_idx_in    (hit_idx_c[i]),
			.empty_idx_in  (empty_idx_c[i]),
			.best_age_in   (best_age_c[i]),
			.best_idx_in   (best_idx_c[i]),
			.best_page_in  (best_page_c[i]),
			// The last cell keeps its packet until the result register can take it.
			.hold          ((i == FRAMES - 1) ? !commit : 1'b0),
			.flags_out     (flags_c[i+1]),
			.page_out      (page_c[i+1]),
			.hit_idx_out   (hit_idx_c[i+1]),
			.empty_idx_out (empty_idx_c[i+1]),
			.best_age_out  (best_age_c[i+1]),
			.best_idx_out  (best_idx_c[i+1]),
			.best_page_out (best_page_c[i+1]),
			.upd           (upd),
			.upd_slot      (dec_slot),
			.upd_page      (page_c[FRAMES])
		);
	end

	// The finished packet completes once the result register is free or being drained.
	assign commit = flags_c[FRAMES].valid && (!out_valid_q || !out_stall);

	// Hit first, then the lowest empty frame, then the oldest frame.
	always_comb begin
		dec_fault  = 1'b1;
		dec_victim = 1'b0;
		priority if (flags_c[FRAMES].hit) begin
			dec_slot  = hit_idx_c[FRAMES];
			dec_fault = 1'b0;
		end else if (flags_c[FRAMES].empty_found) begin
			dec_slot = empty_idx_c[FRAMES];
		end else begin
			dec_slot   = best_idx_c[FRAMES];
			dec_victim = 1'b1;
		end
	end

	assign upd.commit = commit;
	assign upd.write  = dec_fault;

	assign slot_ext   = {{SLOT_PORT_BITS{1'b0}}, dec_slot};
	assign victim_ext = {{PAGE_PORT_BITS{1'b0}}, best_page_c[FRAMES]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			fault_count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (dec_fault && fault_count_q != COUNT_MAX) begin
					fault_count_q <= fault_count_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the fault total is read from the count after this request.
	always_ff @(posedge clk) begin
		if (commit) begin
			fault_q        <= dec_fault;
			slot_q         <= slot_ext[SLOT_PORT_BITS-1:0];
			victim_valid_q <= dec_victim;
			victim_page_q  <= dec_victim ? victim_ext[PAGE_PORT_BITS-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign fault        = fault_q;
	assign frame_slot   = slot_q;
	assign victim_valid = victim_valid_q;
	assign victim_page  = victim_page_q;
	assign fault_total  = fault_count_q;

endmodule

>>> tb/tb_lru_page_replacement_unit.sv
// Self-checking testbench for the LRU page replacement unit with its own LRU predictor.
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;

	import lrupr_pkg::*;

	// The unit is built at its default size. The predictor below uses the same values.
	localparam int FRAMES    = 4;
	localparam int PAGE_BITS = 8;
	localparam int AGE_BITS  = 16;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	// The settle time at the end is longer than a result takes to cross the row of
	// cells, so that a stray result still shows up.
	localparam int SETTLE_CYCLES = 4 * (FRAMES + 1);

	// Only the first mismatches are printed. All of them are counted.
	localparam int PRINT_LIMIT = 40;

	// One expected result of a page request, in the widths of the output ports.
	typedef struct packed {
		logic                      fault;
		logic [SLOT_PORT_BITS-1:0] frame_slot;
		logic                      victim_valid;
		logic [PAGE_PORT_BITS-1:0] victim_page;
		logic [COUNT_BITS-1:0]     fault_total;
	} page_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [PAGE_PORT_BITS-1:0] page_number = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      fault;
	logic [SLOT_PORT_BITS-1:0] frame_slot;
	logic                      victim_valid;
	logic [PAGE_PORT_BITS-1:0] victim_page;
	logic [COUNT_BITS-1:0]     fault_total;

	// Predicted contents of the frames, kept apart from the unit.
	logic                 frame_held [FRAMES];
	logic [PAGE_BITS-1:0] frame_owner [FRAMES];
	logic [AGE_BITS-1:0]  frame_idle [FRAMES];
	logic [COUNT_BITS-1:0] faults_so_far;

	// Results that the unit still owes, oldest first.
	page_result_t pending_results [$];

	int mismatch_count = 0;
	int results_seen = 0;
	int stall_left = 0;

	// Largest gap that the sender and the receiver draw before each request or result.
	// Zero gives stretches with no idling at all.
	int tx_idle_max = 17;
	int rx_idle_max = 17;

	lru_page_replacement_unit #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS),
		.AGE_BITS (AGE_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.page_number (page_number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fault       (fault),
		.frame_slot  (frame_slot),
		.victim_valid(victim_valid),
		.victim_page (victim_page),
		.fault_total (fault_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result of one page reference and moves the predicted frames on.
	// A hit keeps its frame. A miss counts a fault (stopping at the top of the counter)
	// and takes the lowest empty frame, or else evicts the frame with the greatest age,
	// where the first of several equal ages wins. Then every valid frame ages by one,
	// stopping at the top of its range, and the frame just used starts again at zero.
	function automatic page_result_t predict_reference(input logic [PAGE_BITS-1:0] page);
		page_result_t r;
		int slot;
		logic [AGE_BITS-1:0] oldest;
		r = '0;
		slot = -1;
		for (int i = 0; i < FRAMES; i++) begin
			if (slot < 0 && frame_held[i] && frame_owner[i] == page) begin
				slot = i;
			end
		end
		if (slot < 0) begin
			r.fault = 1'b1;
			if (faults_so_far != COUNT_MAX) begin
				faults_so_far++;
			end
			for (int i = 0; i < FRAMES; i++) begin
				if (slot < 0 && !frame_held[i]) begin
					slot = i;
				end
			end
			if (slot < 0) begin
				// Every frame is taken: the strict compare keeps the lowest index on a tie.
				slot = 0;
				oldest = frame_idle[0];
				for (int i = 1; i < FRAMES; i++) begin
					if (frame_idle[i] > oldest) begin
						oldest = frame_idle[i];
						slot = i;
					end
				end
				r.victim_valid = 1'b1;
				r.victim_page = PAGE_PORT_BITS'(frame_owner[slot]);
			end
			frame_owner[slot] = page;
			frame_held[slot] = 1'b1;
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (frame_held[i] && frame_idle[i] != AGE_MAX) begin
				frame_idle[i]++;
			end
		end
		frame_idle[slot] = '0;
		r.frame_slot = SLOT_PORT_BITS'(slot);
		r.fault_total = faults_so_far;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("%0t: result %0d, %s is %0d, expected %0d",
				$realtime, results_seen, field, got, want);
		end
		mismatch_count++;
	endtask

	// Sends one page request. The sender first idles for a drawn number of cycles; with
	// no gap, valid simply stays high from the previous request. The expected result is
	// queued at the edge where the request is taken.
	task automatic send_page(input logic [PAGE_PORT_BITS-1:0] page);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		page_number <= page;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_reference(page[PAGE_BITS-1:0]));
	endtask

	// Holds the sender back until every expected result has come out. This also puts
	// the unit through an empty pipeline between the test phases.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Receiver: takes a result at every edge where valid is high and stall is low,
	// compares it with the oldest expectation, then draws how long to stall next.
	always @(posedge clk) begin
		page_result_t want;
		int n;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, fault_total", int'(fault_total), 0);
			end else begin
				want = pending_results.pop_front();
				if (fault !== want.fault)
					report_mismatch("fault", int'(fault), int'(want.fault));
				if (frame_slot !== want.frame_slot)
					report_mismatch("frame_slot", int'(frame_slot),
						int'(want.frame_slot));
				if (victim_valid !== want.victim_valid)
					report_mismatch("victim_valid", int'(victim_valid),
						int'(want.victim_valid));
				if (victim_page !== want.victim_page)
					report_mismatch("victim_page", int'(victim_page),
						int'(want.victim_page));
				if (fault_total !== want.fault_total)
					report_mismatch("fault_total", int'(fault_total),
						int'(want.fault_total));
			end
			results_seen++;
			n = $urandom_range(0, rx_idle_max);
			stall_left <= n;
			out_stall <= (n != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end
	end

	// Frames fill in index order from empty. A repeat of the very first page must hit
	// while only one frame holds anything. The pages cover both extremes of the field
	// and both values of every bit.
	task automatic test_fill_empty_frames();
		send_page(8'h00);
		send_page(8'h00);
		send_page(8'hFF);
		send_page(8'h5A);
		send_page(8'hA5);
		wait_for_results();
	endtask

	// Hits in every frame, in an order that shuffles the recency ranking.
	task automatic test_hits_all_frames();
		send_page(8'hFF);
		send_page(8'hA5);
		send_page(8'h00);
		send_page(8'h5A);
		send_page(8'hFF);
		wait_for_results();
	endtask

	// Misses with all frames full, so each one evicts the least recently used page;
	// the victims include the extreme pages and then pages placed earlier in this test.
	task automatic test_lru_eviction();
		send_page(8'h3C);
		send_page(8'hC3);
		send_page(8'h01);
		send_page(8'h80);
		send_page(8'h00);
		send_page(8'h3C);
		send_page(8'hFF);
		wait_for_results();
	endtask

	// Random traffic in stretches. Each stretch picks a working set of two to eight
	// pages: up to four of them settle into hits, more of them keep evicting. One
	// request in ten is an arbitrary page. Each stretch also picks its own idling,
	// from none on either side to long gaps on both.
	task automatic test_random_traffic(input int count);
		logic [PAGE_PORT_BITS-1:0] pool [8];
		int set_size;
		int sent;
		int stretch;
		sent = 0;
		while (sent < count) begin
			set_size = $urandom_range(2, 8);
			for (int i = 0; i < 8; i++) begin
				pool[i] = PAGE_PORT_BITS'($urandom_range(0, 255));
			end
			case ($urandom_range(0, 3))
				0: begin
					tx_idle_max = 0;
					rx_idle_max = 0;
				end
				1: begin
					tx_idle_max = 17;
					rx_idle_max = 0;
				end
				2: begin
					tx_idle_max = 0;
					rx_idle_max = 17;
				end
				default: begin
					tx_idle_max = 17;
					rx_idle_max = 17;
				end
			endcase
			stretch = $urandom_range(20, 60);
			repeat (stretch) begin
				if ($urandom_range(0, 9) == 0) begin
					send_page(PAGE_PORT_BITS'($urandom_range(0, 255)));
				end else begin
					send_page(pool[$urandom_range(0, set_size - 1)]);
				end
				sent++;
			end
			if ($urandom_range(0, 3) == 0) begin
				wait_for_results();
			end
		end
		wait_for_results();
	endtask

	// Saturated ages. After four distinct references the frames hold exactly those
	// pages. Hitting only the last two for longer than the age range lets the other
	// two frames both reach the top age, so they tie. The next miss must evict the
	// lower-indexed of the two, and the one after it the other.
	task automatic test_age_saturation();
		tx_idle_max = 0;
		rx_idle_max = 0;
		send_page(8'hC4);
		send_page(8'hC5);
		send_page(8'hC6);
		send_page(8'hC7);
		for (int i = 0; i < int'(AGE_MAX) + 4; i++) begin
			send_page((i % 2 == 0) ? 8'hC6 : 8'hC7);
		end
		send_page(8'h21);
		send_page(8'h22);
		send_page(8'hC6);
		wait_for_results();
	endtask

	// Saturated fault count. A ring of five pages never hits in four LRU frames, so
	// every request faults. The ring runs until the counter has stopped at its top,
	// and a few more faults must leave it there.
	task automatic test_fault_count_saturation();
		int k;
		tx_idle_max = 0;
		rx_idle_max = 0;
		k = 0;
		while (faults_so_far != COUNT_MAX) begin
			send_page(PAGE_PORT_BITS'(8'h10 + k % 5));
			k++;
		end
		repeat (8) begin
			send_page(PAGE_PORT_BITS'(8'h10 + k % 5));
			k++;
		end
		wait_for_results();
	endtask

	initial begin
		for (int i = 0; i < FRAMES; i++) begin
			frame_held[i] = 1'b0;
			frame_owner[i] = '0;
			frame_idle[i] = '0;
		end
		faults_so_far = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_fill_empty_frames();
		test_hits_all_frames();
		test_lru_eviction();
		test_random_traffic(850);
		test_age_saturation();
		test_fault_count_saturation();

		// Every request has been taken and every expected result has come; give a
		// stray extra result time to appear before the verdict.
		in_valid <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this time.
	initial begin
		#100_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
